// ===== rtl/gmmc_pkg.sv =====
// package for the minimax manhattan center unit
// holds field widths, reset values, register indexes and a width helper
// no dependencies
package gmmc_pkg;

    localparam int DEF_MAX_ROWS = 64;
    localparam int DEF_MAX_COLS = 64;

    localparam int COUNT_W    = 7;
    localparam int ROW_OUT_W  = 6;
    localparam int COL_OUT_W  = 6;
    localparam int DIST_OUT_W = 7;
    localparam int CFG_IDX_W  = 1;

    localparam logic [COUNT_W-1:0] COUNT_RST = 7'd64;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROW_COUNT = 1'b0,
        CFG_COL_COUNT = 1'b1
    } t_cfg_idx;

    // index width for a store of n entries, never below one bit
    function automatic int idx_w(input int n);
        int w;
        w = $clog2(n);
        return (w < 1) ? 1 : w;
    endfunction

endpackage

// ===== rtl/gmmc_ram.sv =====
// generic single write port, single read port ram with registered read
// depends on gmmc_pkg for the address width helper
module gmmc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [gmmc_pkg::idx_w(DEPTH)-1:0]     i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic [gmmc_pkg::idx_w(DEPTH)-1:0]     i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/gmmc_reach.sv =====
// shared reach unit: column span of one row and the running row reach
// used by both the forward and the backward sweep; no package dependency
module gmmc_reach #(
    parameter int CW = 6,
    parameter int DW = 7
) (
    input  logic [CW-1:0] i_col,
    input  logic          i_has,
    input  logic [CW-1:0] i_first,
    input  logic [CW-1:0] i_last,
    input  logic          i_row_ok,
    input  logic          i_seen,
    input  logic [DW-1:0] i_run,
    output logic [DW-1:0] o_reach,
    output logic          o_seen
);

    logic [CW-1:0] dist_first;
    logic [CW-1:0] dist_last;
    logic [DW-1:0] span;
    logic [DW-1:0] base;
    logic          black;

    always_comb begin
        dist_first = (i_col >= i_first) ? i_col - i_first : i_first - i_col;
        dist_last  = (i_col >= i_last) ? i_col - i_last : i_last - i_col;
        span       = (dist_first > dist_last) ? DW'(dist_first) : DW'(dist_last);
        base       = i_seen ? i_run + 1'b1 : '0;
        black      = i_has && i_row_ok;
        o_reach    = (black && span > base) ? span : base;
        o_seen     = i_seen || black;
    end

endmodule

// ===== rtl/grid_minimax_manhattan_center_unit.sv =====
// minimax manhattan center of a binary image loaded in raster order
// load: one pixel transaction per cycle while o_stall is low; search after the last pixel
// runs a forward and a backward sweep per column through one shared reach unit and two rams,
// then the result is held until taken; no input is taken during search or while held.
// synchronous active-low reset: counts to 64, load position to zero,
// no clearing pass (unloaded rows are masked by the load position)
module grid_minimax_manhattan_center_unit #(
    parameter int MAX_ROWS = gmmc_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS = gmmc_pkg::DEF_MAX_COLS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [gmmc_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [gmmc_pkg::COUNT_W-1:0]       i_cfg_data,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic                               i_pixel_black,
    input  logic                               i_last_pixel,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic [gmmc_pkg::ROW_OUT_W-1:0]     o_center_row,
    output logic [gmmc_pkg::COL_OUT_W-1:0]     o_center_col,
    output logic [gmmc_pkg::DIST_OUT_W-1:0]    o_max_distance
);

    localparam int RW  = gmmc_pkg::idx_w(MAX_ROWS);
    localparam int CW  = gmmc_pkg::idx_w(MAX_COLS);
    localparam int RCW = $clog2(MAX_ROWS + 1);
    localparam int DW  = gmmc_pkg::idx_w(MAX_ROWS + MAX_COLS - 1);
    localparam int IW  = 1 + 2 * CW;

    typedef enum logic [2:0] {
        S_LOAD,
        S_FWD,
        S_BWD,
        S_COLEND,
        S_OUT
    } t_state;

    t_state                        r_state;
    logic [gmmc_pkg::COUNT_W-1:0]  r_row_count;
    logic [gmmc_pkg::COUNT_W-1:0]  r_col_count;
    logic [RCW-1:0]                r_load_row;
    logic [CW-1:0]                 r_load_col;
    logic                          r_cur_has;
    logic [CW-1:0]                 r_cur_first;
    logic [CW-1:0]                 r_cur_last;
    logic [RW-1:0]                 r_addr;
    logic                          r_issue_on;
    logic                          r_pv;
    logic [RW-1:0]                 r_prow;
    logic [CW-1:0]                 r_col;
    logic                          r_seen;
    logic [DW-1:0]                 r_run;
    logic                          r_col_first;
    logic [DW-1:0]                 r_col_best;
    logic [RW-1:0]                 r_col_row;
    logic                          r_best_first;
    logic [DW-1:0]                 r_best_dist;
    logic [RW-1:0]                 r_best_row;
    logic [CW-1:0]                 r_best_col;

    logic [RW-1:0] rows_m1;
    logic [CW-1:0] cols_m1;
    logic          in_acc;
    logic          in_grid;
    logic          has_in;
    logic          has_n;
    logic [CW-1:0] first_n;
    logic [CW-1:0] last_n;
    logic          info_we;
    logic [IW-1:0] info_wdata;
    logic [IW-1:0] info_rdata;
    logic          fwd_we;
    logic [DW-1:0] fwd_rdata;
    logic          row_ok;
    logic [DW-1:0] reach;
    logic          seen_n;
    logic [DW-1:0] bwd_dist;
    logic          take;

    // clamp the counts to 1..max
    always_comb begin
        if (r_row_count == '0) begin
            rows_m1 = '0;
        end else if (int'(r_row_count) > MAX_ROWS) begin
            rows_m1 = RW'(MAX_ROWS - 1);
        end else begin
            rows_m1 = RW'(r_row_count - 1'b1);
        end
        if (r_col_count == '0) begin
            cols_m1 = '0;
        end else if (int'(r_col_count) > MAX_COLS) begin
            cols_m1 = CW'(MAX_COLS - 1);
        end else begin
            cols_m1 = CW'(r_col_count - 1'b1);
        end
    end

    assign o_stall = (r_state != S_LOAD);
    assign in_acc  = i_valid && !o_stall;
    assign in_grid = (r_load_row <= RCW'(rows_m1));

    // running first and last black column of the row being loaded
    always_comb begin
        has_in     = (r_load_col != '0) && r_cur_has;
        has_n      = has_in || i_pixel_black;
        first_n    = (i_pixel_black && !has_in) ? r_load_col : r_cur_first;
        last_n     = i_pixel_black ? r_load_col : r_cur_last;
        info_we    = in_acc && in_grid;
        info_wdata = {has_n, first_n, last_n};
    end

    gmmc_ram #(
        .WIDTH (IW),
        .DEPTH (MAX_ROWS)
    ) u_row_info (
        .i_clk   (i_clk),
        .i_we    (info_we),
        .i_waddr (r_load_row[RW-1:0]),
        .i_wdata (info_wdata),
        .i_raddr (r_addr),
        .o_rdata (info_rdata)
    );

    // rows not yet reached by loading count as white
    assign row_ok = (RCW'(r_prow) < r_load_row)
                 || ((RCW'(r_prow) == r_load_row) && (r_load_col != '0));

    gmmc_reach #(
        .CW (CW),
        .DW (DW)
    ) u_reach (
        .i_col    (r_col),
        .i_has    (info_rdata[IW-1]),
        .i_first  (info_rdata[2*CW-1:CW]),
        .i_last   (info_rdata[CW-1:0]),
        .i_row_ok (row_ok),
        .i_seen   (r_seen),
        .i_run    (r_run),
        .o_reach  (reach),
        .o_seen   (seen_n)
    );

    assign fwd_we = (r_state == S_FWD) && r_pv;

    gmmc_ram #(
        .WIDTH (DW),
        .DEPTH (MAX_ROWS)
    ) u_fwd_reach (
        .i_clk   (i_clk),
        .i_we    (fwd_we),
        .i_waddr (r_prow),
        .i_wdata (reach),
        .i_raddr (r_addr),
        .o_rdata (fwd_rdata)
    );

    assign bwd_dist = (fwd_rdata > reach) ? fwd_rdata : reach;
    assign take     = r_col_first || (bwd_dist <= r_col_best);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_LOAD;
            r_row_count  <= gmmc_pkg::COUNT_RST;
            r_col_count  <= gmmc_pkg::COUNT_RST;
            r_load_row   <= '0;
            r_load_col   <= '0;
            r_cur_has    <= 1'b0;
            r_issue_on   <= 1'b0;
            r_pv         <= 1'b0;
            r_col_first  <= 1'b0;
            r_best_first <= 1'b0;
        end else begin
            unique case (r_state)
                S_LOAD: begin
                    if (in_acc) begin
                        if (in_grid && !i_cfg_we) begin
                            r_cur_has   <= has_n;
                            r_cur_first <= first_n;
                            r_cur_last  <= last_n;
                            if (r_load_col == cols_m1) begin
                                r_load_col <= '0;
                                r_load_row <= r_load_row + 1'b1;
                            end else begin
                                r_load_col <= r_load_col + 1'b1;
                            end
                        end
                        if (i_last_pixel) begin
                            r_state      <= S_FWD;
                            r_col        <= '0;
                            r_addr       <= '0;
                            r_issue_on   <= 1'b1;
                            r_seen       <= 1'b0;
                            r_run        <= '0;
                            r_best_first <= 1'b1;
                        end
                    end
                end
                S_FWD: begin
                    if (r_issue_on) begin
                        r_prow <= r_addr;
                        r_pv   <= 1'b1;
                        if (r_addr == rows_m1) begin
                            r_issue_on <= 1'b0;
                        end else begin
                            r_addr <= r_addr + 1'b1;
                        end
                    end else begin
                        r_pv <= 1'b0;
                    end
                    if (r_pv) begin
                        if (r_prow == rows_m1) begin
                            r_state     <= S_BWD;
                            r_addr      <= rows_m1;
                            r_issue_on  <= 1'b1;
                            r_seen      <= 1'b0;
                            r_run       <= '0;
                            r_col_first <= 1'b1;
                        end else begin
                            r_run  <= reach;
                            r_seen <= seen_n;
                        end
                    end
                end
                S_BWD: begin
                    if (r_issue_on) begin
                        r_prow <= r_addr;
                        r_pv   <= 1'b1;
                        if (r_addr == '0) begin
                            r_issue_on <= 1'b0;
                        end else begin
                            r_addr <= r_addr - 1'b1;
                        end
                    end else begin
                        r_pv <= 1'b0;
                    end
                    if (r_pv) begin
                        r_run  <= reach;
                        r_seen <= seen_n;
                        if (take) begin
                            r_col_best  <= bwd_dist;
                            r_col_row   <= r_prow;
                            r_col_first <= 1'b0;
                        end
                        if (r_prow == '0) begin
                            r_state <= S_COLEND;
                        end
                    end
                end
                S_COLEND: begin
                    if (r_best_first || (r_col_best < r_best_dist)) begin
                        r_best_dist  <= r_col_best;
                        r_best_row   <= r_col_row;
                        r_best_col   <= r_col;
                        r_best_first <= 1'b0;
                    end
                    if (r_col == cols_m1) begin
                        r_state <= S_OUT;
                    end else begin
                        r_state    <= S_FWD;
                        r_col      <= r_col + 1'b1;
                        r_addr     <= '0;
                        r_issue_on <= 1'b1;
                        r_seen     <= 1'b0;
                        r_run      <= '0;
                    end
                end
                S_OUT: begin
                    if (!i_stall) begin
                        r_state    <= S_LOAD;
                        r_load_row <= '0;
                        r_load_col <= '0;
                    end
                end
                default: begin
                    r_state <= S_LOAD;
                end
            endcase
            // register write in the load state restarts the image
            if (i_cfg_we) begin
                unique case (gmmc_pkg::t_cfg_idx'(i_cfg_idx))
                    gmmc_pkg::CFG_ROW_COUNT: r_row_count <= i_cfg_data;
                    gmmc_pkg::CFG_COL_COUNT: r_col_count <= i_cfg_data;
                    default: ;
                endcase
                if (r_state == S_LOAD) begin
                    r_load_row <= '0;
                    r_load_col <= '0;
                end
            end
        end
    end

    assign o_valid        = (r_state == S_OUT);
    assign o_center_row   = gmmc_pkg::ROW_OUT_W'(r_best_row);
    assign o_center_col   = gmmc_pkg::COL_OUT_W'(r_best_col);
    assign o_max_distance = gmmc_pkg::DIST_OUT_W'(r_best_dist);

`ifndef ASSERT_OFF
    a_last_starts_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOAD && in_acc && i_last_pixel && !i_cfg_we)
        |=> (r_state == S_FWD && r_col == '0 && r_issue_on))
        else $error("last pixel did not start the search at column zero");

    a_column_picked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_COLEND) |-> !r_col_first)
        else $error("backward sweep ended without a candidate row");

    a_dist_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (int'(r_best_dist) <= int'(rows_m1) + int'(cols_m1)))
        else $error("result distance exceeds the grid diameter");

    a_load_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (int'(r_load_row) <= int'(rows_m1) + 1))
        else $error("load position ran past the last row");
`endif

endmodule
